// File: rtl/core/heater_power_step_controller_macros.svh
// assertion macros shared by the heater power step controller modules
`ifndef HEATER_POWER_STEP_CONTROLLER_MACROS_SVH
`define HEATER_POWER_STEP_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on the block clock
`define HPSC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heater power step controller: implication check failed");

// next-cycle implication, sampled on the block clock
`define HPSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heater power step controller: next-cycle check failed");

`endif

// File: rtl/core/hpsc_pkg.sv
// shared types and constants of the heater power step controller
package hpsc_pkg;

   // field widths
   localparam int TempWidth    = 14;
   localparam int RampWidth    = 13;
   localparam int RateWidth    = 12;
   localparam int LevelWidth   = 3;
   localparam int ErrWidth     = TempWidth + 1;
   localparam int ProjWidth    = 25;
   localparam int DivNumWidth  = 15;
   localparam int DivDenWidth  = 10;
   localparam int DivSteps     = DivNumWidth;
   localparam int CountWidth   = $clog2(DivSteps);
   localparam int PaddrWidth   = 5;
   localparam int DataWidth    = 32;

   // level limits
   localparam logic [LevelWidth-1:0] LevelOff    = 3'd0;
   localparam logic [LevelWidth-1:0] LevelSteady = 3'd2;
   localparam logic [LevelWidth-1:0] LevelMax    = 3'd4;

   // register reset values
   localparam logic [9:0]  HysteresisReset       = 10'd16;
   localparam logic [9:0]  LookaheadReset        = 10'd32;
   localparam logic [9:0]  ErrorPerLevelReset    = 10'd80;
   localparam logic [11:0] SteadyRampLimitReset  = 12'd26;
   localparam logic [13:0] LargeSteadyErrorReset = 14'd160;

   // register indexes
   typedef enum logic [2:0] {
      REG_HYSTERESIS         = 3'd0,
      REG_LOOKAHEAD_TIME     = 3'd1,
      REG_ERROR_PER_LEVEL    = 3'd2,
      REG_STEADY_RAMP_LIMIT  = 3'd3,
      REG_LARGE_STEADY_ERROR = 3'd4
   } reg_idx_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_CHECK,
      ST_DIVIDE,
      ST_RESOLVE,
      ST_DELIVER
   } state_type;

   // configuration registers
   typedef struct packed {
      logic [9:0]  hysteresis;
      logic [9:0]  lookahead_time;
      logic [9:0]  error_per_level;
      logic [11:0] steady_ramp_limit;
      logic [13:0] large_steady_error;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic calc;
      logic div_init;
      logic div_step;
      logic load_off;
      logic load_hold;
      logic load_calc;
      logic publish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic force_off;
      logic in_band;
   } sts_type;

endpackage

// File: rtl/core/hpsc_csr.sv
// configuration register file with apb-style access
module hpsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hpsc_pkg::PaddrWidth-1:0]     csr_paddr,
   input  logic [hpsc_pkg::DataWidth-1:0]      csr_pwdata,
   output logic [hpsc_pkg::DataWidth-1:0]      csr_prdata,
   output logic                                csr_pready,
   output hpsc_pkg::cfg_type                   cfg
);

   hpsc_pkg::cfg_type     cfg_ff, cfg_in;
   hpsc_pkg::reg_idx_type reg_idx;
   logic                  wr_en;

   assign reg_idx    = hpsc_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            hpsc_pkg::REG_HYSTERESIS:         cfg_in.hysteresis = csr_pwdata[9:0];
            hpsc_pkg::REG_LOOKAHEAD_TIME:     cfg_in.lookahead_time = csr_pwdata[9:0];
            hpsc_pkg::REG_ERROR_PER_LEVEL:    cfg_in.error_per_level = csr_pwdata[9:0];
            hpsc_pkg::REG_STEADY_RAMP_LIMIT:  cfg_in.steady_ramp_limit = csr_pwdata[11:0];
            hpsc_pkg::REG_LARGE_STEADY_ERROR: cfg_in.large_steady_error = csr_pwdata[13:0];
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         hpsc_pkg::REG_HYSTERESIS:        csr_prdata = {22'd0, cfg_ff.hysteresis};
         hpsc_pkg::REG_LOOKAHEAD_TIME:    csr_prdata = {22'd0, cfg_ff.lookahead_time};
         hpsc_pkg::REG_ERROR_PER_LEVEL:   csr_prdata = {22'd0, cfg_ff.error_per_level};
         hpsc_pkg::REG_STEADY_RAMP_LIMIT: csr_prdata = {20'd0, cfg_ff.steady_ramp_limit};
         hpsc_pkg::REG_LARGE_STEADY_ERROR:
            csr_prdata = {{18{cfg_ff.large_steady_error[13]}}, cfg_ff.large_steady_error};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hysteresis         <= hpsc_pkg::HysteresisReset;
         cfg_ff.lookahead_time     <= hpsc_pkg::LookaheadReset;
         cfg_ff.error_per_level    <= hpsc_pkg::ErrorPerLevelReset;
         cfg_ff.steady_ramp_limit  <= hpsc_pkg::SteadyRampLimitReset;
         cfg_ff.large_steady_error <= hpsc_pkg::LargeSteadyErrorReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/hpsc_divider.sv
// restoring divider, one quotient bit per step
`include "heater_power_step_controller_macros.svh"

module hpsc_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                div_init,
   input  logic                                div_step,
   input  logic [hpsc_pkg::DivNumWidth-1:0]    numerator,
   input  logic [hpsc_pkg::DivDenWidth-1:0]    divisor,
   output logic [hpsc_pkg::DivNumWidth-1:0]    quotient
);

   logic [hpsc_pkg::DivDenWidth-1:0] rem_ff, rem_in;
   logic [hpsc_pkg::DivDenWidth-1:0] den_ff, den_in;
   logic [hpsc_pkg::DivNumWidth-1:0] quo_ff, quo_in;
   logic [hpsc_pkg::DivDenWidth:0]   shifted;
   logic [hpsc_pkg::DivDenWidth:0]   diff;
   logic                             fits;

   // trial subtract of the shifted partial remainder
   assign shifted = {rem_ff, quo_ff[hpsc_pkg::DivNumWidth-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      if (div_init) begin
         rem_in = '0;
         den_in = divisor;
         quo_in = numerator;
      end else if (div_step) begin
         rem_in = fits ? diff[hpsc_pkg::DivDenWidth-1:0]
                       : shifted[hpsc_pkg::DivDenWidth-1:0];
         quo_in = {quo_ff[hpsc_pkg::DivNumWidth-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

   // partial remainder always stays below the divisor
   `HPSC_ASSERT_IMP(a_rem_below_divisor, div_step, rem_ff < den_ff)

endmodule

// File: rtl/core/hpsc_datapath.sv
// datapath: error terms, feedforward, correction and level registers
`include "heater_power_step_controller_macros.svh"

module hpsc_datapath (
   input  logic                                       clock,
   input  logic                                       reset,
   input  hpsc_pkg::cmd_type                          cmd,
   output hpsc_pkg::sts_type                          sts,
   input  hpsc_pkg::cfg_type                          cfg,
   input  logic signed [hpsc_pkg::TempWidth-1:0]      req_target_temp,
   input  logic signed [hpsc_pkg::TempWidth-1:0]      req_actual_temp,
   input  logic signed [hpsc_pkg::RampWidth-1:0]      req_target_ramp,
   input  logic signed [hpsc_pkg::RampWidth-1:0]      req_actual_ramp,
   input  logic [hpsc_pkg::RateWidth-1:0]             req_heating_rate,
   output logic [hpsc_pkg::LevelWidth-1:0]            rsp_power_level
);

   // captured transaction
   logic signed [hpsc_pkg::TempWidth-1:0] tt_ff, at_ff;
   logic signed [hpsc_pkg::RampWidth-1:0] tr_ff, ar_ff;
   logic [hpsc_pkg::RateWidth-1:0]        rate_ff;

   // first stage results
   logic signed [hpsc_pkg::ErrWidth-1:0]  err_ff, err_calc;
   logic signed [hpsc_pkg::ProjWidth-1:0] prod_ff, prod_calc;
   logic [hpsc_pkg::LevelWidth-1:0]       ff_ff, ff_calc;

   // level registers
   logic [hpsc_pkg::LevelWidth-1:0] level_ff, level_in;
   logic [hpsc_pkg::LevelWidth-1:0] held_ff, held_in;
   logic [hpsc_pkg::LevelWidth-1:0] rsp_level_ff, rsp_level_in;

   // calc stage signals
   logic signed [hpsc_pkg::RampWidth-1:0] ar_pos;
   logic signed [hpsc_pkg::RampWidth:0]   ramp_diff;
   logic [15:0]                           ff_num, ff_d1, ff_d2, ff_d3, ff_d4;

   // check stage signals
   logic signed [15:0]                     err_ext, neg_hyst, lse_ext;
   logic signed [hpsc_pkg::ProjWidth-1:0]  proj, neg_hyst_proj;
   logic [hpsc_pkg::ErrWidth-1:0]          abs_full;
   logic [hpsc_pkg::TempWidth-1:0]         abs_err;
   logic [hpsc_pkg::DivDenWidth-1:0]       divisor;
   logic [hpsc_pkg::DivNumWidth-1:0]       numerator;
   logic [hpsc_pkg::DivNumWidth-1:0]       quotient;

   // resolve stage signals
   logic [hpsc_pkg::DivNumWidth-1:0] corr;
   logic signed [16:0]               steps, capped;
   logic                             steady;
   logic [hpsc_pkg::LevelWidth-1:0]  calc_level;

   // error, lookahead product and rounded feedforward
   assign err_calc  = {tt_ff[13], tt_ff} - {at_ff[13], at_ff};
   assign ar_pos    = ar_ff[12] ? '0 : ar_ff;
   assign ramp_diff = {tr_ff[12], tr_ff} - {ar_pos[12], ar_pos};
   assign prod_calc = 25'(ramp_diff) * 25'($signed({1'b0, cfg.lookahead_time}));
   assign ff_num    = {1'b0, tr_ff[11:0], 3'b000} + {4'd0, rate_ff};
   assign ff_d1     = {3'd0, rate_ff, 1'b0};
   assign ff_d2     = {ff_d1[14:0], 1'b0};
   assign ff_d4     = {ff_d1[13:0], 2'b00};
   assign ff_d3     = ff_d2 + ff_d1;

   always_comb begin
      if (rate_ff == '0)          ff_calc = 3'd0;
      else if (ff_num >= ff_d4)   ff_calc = 3'd4;
      else if (ff_num >= ff_d3)   ff_calc = 3'd3;
      else if (ff_num >= ff_d2)   ff_calc = 3'd2;
      else if (ff_num >= ff_d1)   ff_calc = 3'd1;
      else                        ff_calc = 3'd0;
   end

   // overshoot, projected overshoot and dead band checks
   assign err_ext       = {err_ff[14], err_ff};
   assign neg_hyst      = 16'sd0 - $signed({6'd0, cfg.hysteresis});
   assign proj          = {{2{err_ff[14]}}, err_ff, 8'd0} + prod_ff;
   assign neg_hyst_proj = 25'sd0 - $signed({7'd0, cfg.hysteresis, 8'd0});
   assign abs_full      = err_ff[14] ? (15'd0 - err_ff) : err_ff;
   assign abs_err       = abs_full[13:0];

   assign sts.force_off = tr_ff[12] | (err_ext < neg_hyst) | (proj < neg_hyst_proj);
   assign sts.in_band   = abs_err <= {4'd0, cfg.hysteresis};

   // ceiling division operands
   assign divisor   = (cfg.error_per_level == '0) ? 10'd1 : cfg.error_per_level;
   assign numerator = {1'b0, abs_err} + {5'd0, divisor} - 15'd1;

   hpsc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_init  (cmd.div_init),
      .div_step  (cmd.div_step),
      .numerator (numerator),
      .divisor   (divisor),
      .quotient  (quotient)
   );

   // feedforward plus signed correction, steady cap and clamp
   assign corr    = (quotient == '0) ? 15'd1 : quotient;
   assign lse_ext = {{2{cfg.large_steady_error[13]}}, cfg.large_steady_error};
   assign steady  = (tr_ff[11:0] <= cfg.steady_ramp_limit) & (err_ext < lse_ext);

   always_comb begin
      if (!err_ff[14] && (err_ff != '0)) steps = {14'd0, ff_ff} + {2'd0, corr};
      else                               steps = {14'd0, ff_ff} - {2'd0, corr};
      capped = (steady && (steps > 17'sd2)) ? 17'sd2 : steps;
      if (capped < 17'sd0)      calc_level = hpsc_pkg::LevelOff;
      else if (capped > 17'sd4) calc_level = hpsc_pkg::LevelMax;
      else                      calc_level = capped[2:0];
   end

   // level select and publish
   always_comb begin
      level_in     = level_ff;
      held_in      = held_ff;
      rsp_level_in = rsp_level_ff;
      if (cmd.load_off)       level_in = hpsc_pkg::LevelOff;
      else if (cmd.load_hold) level_in = held_ff;
      else if (cmd.load_calc) level_in = calc_level;
      if (cmd.publish) begin
         held_in      = level_ff;
         rsp_level_in = level_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tt_ff   <= req_target_temp;
         at_ff   <= req_actual_temp;
         tr_ff   <= req_target_ramp;
         ar_ff   <= req_actual_ramp;
         rate_ff <= req_heating_rate;
      end
      if (cmd.calc) begin
         err_ff  <= err_calc;
         prod_ff <= prod_calc;
         ff_ff   <= ff_calc;
      end
      level_ff     <= level_in;
      rsp_level_ff <= rsp_level_in;
   end

   // held level is controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= hpsc_pkg::LevelOff;
      end else begin
         held_ff <= held_in;
      end
   end

   assign rsp_power_level = rsp_level_ff;

   // a published level is in range and matches the stored level
   `HPSC_ASSERT_NEXT(a_publish_level_ok, cmd.publish,
                     (held_ff <= hpsc_pkg::LevelMax) && (rsp_level_ff == held_ff))

endmodule

// File: rtl/core/hpsc_ctrl.sv
// controller state machine sequencing the datapath
`include "heater_power_step_controller_macros.svh"

module hpsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  hpsc_pkg::sts_type sts,
   output hpsc_pkg::cmd_type cmd
);

   hpsc_pkg::state_type                state_ff, state_in;
   logic [hpsc_pkg::CountWidth-1:0]    count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               div_last;
   logic                               slot_free;

   assign div_last  = count_ff == hpsc_pkg::CountWidth'(hpsc_pkg::DivSteps - 1);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hpsc_pkg::ST_IDLE:    if (req_valid) state_in = hpsc_pkg::ST_CALC;
         hpsc_pkg::ST_CALC:    state_in = hpsc_pkg::ST_CHECK;
         hpsc_pkg::ST_CHECK: begin
            if (sts.force_off || sts.in_band) state_in = hpsc_pkg::ST_DELIVER;
            else                              state_in = hpsc_pkg::ST_DIVIDE;
         end
         hpsc_pkg::ST_DIVIDE:  if (div_last) state_in = hpsc_pkg::ST_RESOLVE;
         hpsc_pkg::ST_RESOLVE: state_in = hpsc_pkg::ST_DELIVER;
         hpsc_pkg::ST_DELIVER: if (slot_free) state_in = hpsc_pkg::ST_IDLE;
         default:              state_in = hpsc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hpsc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         hpsc_pkg::ST_CALC:    cmd.calc = 1'b1;
         hpsc_pkg::ST_CHECK: begin
            if (sts.force_off)    cmd.load_off  = 1'b1;
            else if (sts.in_band) cmd.load_hold = 1'b1;
            else                  cmd.div_init  = 1'b1;
         end
         hpsc_pkg::ST_DIVIDE:  cmd.div_step  = 1'b1;
         hpsc_pkg::ST_RESOLVE: cmd.load_calc = 1'b1;
         hpsc_pkg::ST_DELIVER: cmd.publish   = slot_free;
         default: ;
      endcase
   end

   // divide step counter and result valid
   assign count_in     = (state_ff == hpsc_pkg::ST_DIVIDE) ? count_ff + 1'b1 : '0;
   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpsc_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // accepted transaction moves straight into the calc step
   `HPSC_ASSERT_NEXT(a_accept_to_calc, req_valid && req_ready,
                     state_ff == hpsc_pkg::ST_CALC)
   // last divide step hands over to resolve
   `HPSC_ASSERT_NEXT(a_divide_done, (state_ff == hpsc_pkg::ST_DIVIDE) && div_last,
                     state_ff == hpsc_pkg::ST_RESOLVE)
   // publish presents a result and frees the input side
   `HPSC_ASSERT_NEXT(a_publish_shows, cmd.publish,
                     rsp_valid_ff && (state_ff == hpsc_pkg::ST_IDLE))

endmodule

// File: rtl/core/heater_power_step_controller.sv
// heater power step controller: a transaction is forced off or held in band, or its
// level is computed by the 15-step serial divider. The result sits in an output
// register and the next transaction is taken while it waits.
// synchronous active-high reset clears the state machine, result valid, held level
// (heater off) and the configuration registers to their defaults.
module heater_power_step_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [hpsc_pkg::TempWidth-1:0]  req_target_temp,
   input  logic signed [hpsc_pkg::TempWidth-1:0]  req_actual_temp,
   input  logic signed [hpsc_pkg::RampWidth-1:0]  req_target_ramp,
   input  logic signed [hpsc_pkg::RampWidth-1:0]  req_actual_ramp,
   input  logic [hpsc_pkg::RateWidth-1:0]         req_heating_rate,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [hpsc_pkg::LevelWidth-1:0]        rsp_power_level,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [hpsc_pkg::PaddrWidth-1:0]        csr_paddr,
   input  logic [hpsc_pkg::DataWidth-1:0]         csr_pwdata,
   output logic [hpsc_pkg::DataWidth-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   hpsc_pkg::cfg_type cfg;
   hpsc_pkg::cmd_type cmd;
   hpsc_pkg::sts_type sts;

   // configuration registers
   hpsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencing
   hpsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic
   hpsc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg),
      .req_target_temp  (req_target_temp),
      .req_actual_temp  (req_actual_temp),
      .req_target_ramp  (req_target_ramp),
      .req_actual_ramp  (req_actual_ramp),
      .req_heating_rate (req_heating_rate),
      .rsp_power_level  (rsp_power_level)
   );

endmodule
